// File: hw/rtl/http_chunked_body_decoder_assert.svh
// Assertion macros shared by the chunked body decoder RTL.
`ifndef HTTP_CHUNKED_BODY_DECODER_ASSERT_SVH
`define HTTP_CHUNKED_BODY_DECODER_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define HCBD_ASSERT_NOW(label, clk, rst_n, cond, prop) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (cond) |-> (prop)) \
		else $error("hcbd same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define HCBD_ASSERT_NEXT(label, clk, rst_n, cond, prop) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (cond) |=> (prop)) \
		else $error("hcbd next-cycle check failed");

`endif

// File: hw/rtl/hcbd_pkg.sv
`default_nettype none
package hcbd_pkg;

	// Default width of the chunk size counter
	localparam int unsigned SIZE_BITS_DEF = 32;

	// Framing characters
	localparam logic [7:0] CH_TAB = 8'h09;
	localparam logic [7:0] CH_LF  = 8'h0A;
	localparam logic [7:0] CH_VT  = 8'h0B;
	localparam logic [7:0] CH_FF  = 8'h0C;
	localparam logic [7:0] CH_CR  = 8'h0D;
	localparam logic [7:0] CH_SP  = 8'h20;

	// Decoder phase, one-hot
	typedef enum logic [4:0] {
		PH_LEAD = 5'b00001,
		PH_SIZE = 5'b00010,
		PH_DATA = 5'b00100,
		PH_TAIL = 5'b01000,
		PH_DONE = 5'b10000
	} phase_t;

	typedef struct packed {
		logic       is_hex;
		logic [3:0] value;
	} hex_t;

	// Decode one ASCII hex digit
	function automatic hex_t hex_decode(input logic [7:0] c);
		hex_t r;
		r.is_hex = 1'b0;
		r.value  = 4'd0;
		if (c >= "0" && c <= "9") begin
			r.is_hex = 1'b1;
			r.value  = 4'(c - 8'h30);
		end else if (c >= "a" && c <= "f") begin
			r.is_hex = 1'b1;
			r.value  = 4'(c - 8'h57);
		end else if (c >= "A" && c <= "F") begin
			r.is_hex = 1'b1;
			r.value  = 4'(c - 8'h37);
		end
		return r;
	endfunction

	// Space, tab, VT, FF and CR are skipped before the size digits
	function automatic logic is_lead_space(input logic [7:0] c);
		return (c == CH_SP) || (c == CH_TAB) || (c == CH_VT) || (c == CH_FF) || (c == CH_CR);
	endfunction

endpackage
`default_nettype wire

// File: hw/rtl/http_chunked_body_decoder.sv
// Chunked transfer body decoder.
// Input channel (in_valid/in_ready): one raw body byte per item in byte_in,
// with new_body set on the first byte of a fresh body to clear all state.
// Output channel (out_valid/out_ready): exactly one item per input item,
// in order. data_valid marks payload bytes in data_byte (zero otherwise),
// chunk_last_byte marks the final byte of each chunk, body_done rises on
// the LF of the zero-size line and stays set until the next new_body,
// size_overflow is sticky once a chunk size no longer fits in SIZE_BITS
// bits (the size then saturates). Between input accept and output valid
// lie the input register, then the result register. Throughput: one item
// per cycle while out_ready is high; the phase and counter update is a
// single step on the input register's byte. Reset (arst_n low) empties
// both stages and returns the decoder to the start of a size line. When
// the receiver stalls, the result register holds and the input register
// still takes one more item; in_ready then drops until out_ready returns.
`default_nettype none
module http_chunked_body_decoder #(
	parameter int unsigned SIZE_BITS = hcbd_pkg::SIZE_BITS_DEF
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_ready,
	input  wire logic [7:0] byte_in,
	input  wire logic       new_body,
	output logic            out_valid,
	input  wire logic       out_ready,
	output logic [7:0]      data_byte,
	output logic            data_valid,
	output logic            chunk_last_byte,
	output logic            body_done,
	output logic            size_overflow
);

	// Input stage
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       new_body_s1;

	// Result stage
	logic       valid_s2;
	logic [7:0] data_byte_s2;
	logic       data_valid_s2;
	logic       last_s2;
	logic       done_s2;
	logic       ovf_s2;

	// Decoder state
	hcbd_pkg::phase_t       phase_q;
	logic [SIZE_BITS-1:0]   count_q;
	logic                   digits_closed_q;
	logic                   overflow_q;

	// Next-state signals
	hcbd_pkg::phase_t       ph_b, ph_n;
	logic [SIZE_BITS-1:0]   cnt_b, cnt_n, cnt_dec, cnt_shift;
	logic                   dc_b, dc_n, ov_b, ov_n;
	logic                   valid_n, last_n;
	hcbd_pkg::hex_t         hex;
	logic                   adv_s1, adv_s2;

	// Pipeline handshake
	assign adv_s2   = valid_s2 && out_ready;
	assign adv_s1   = valid_s1 && (!valid_s2 || out_ready);
	assign in_ready = !valid_s1 || adv_s1;

	assign hex       = hcbd_pkg::hex_decode(byte_s1);
	assign cnt_dec   = cnt_b - SIZE_BITS'(1);
	assign cnt_shift = {cnt_b[SIZE_BITS-5:0], hex.value};

	// Phase and counter update for the byte in the input stage
	always_comb begin
		// New body clears state before this byte
		if (new_body_s1) begin
			ph_b  = hcbd_pkg::PH_LEAD;
			cnt_b = '0;
			dc_b  = 1'b0;
			ov_b  = 1'b0;
		end else begin
			ph_b  = phase_q;
			cnt_b = count_q;
			dc_b  = digits_closed_q;
			ov_b  = overflow_q;
		end
		ph_n    = ph_b;
		cnt_n   = cnt_b;
		dc_n    = dc_b;
		ov_n    = ov_b;
		valid_n = 1'b0;
		last_n  = 1'b0;
		unique case (ph_b)
			hcbd_pkg::PH_LEAD: begin
				if (hcbd_pkg::is_lead_space(byte_s1)) begin
					ph_n = ph_b;
				end else if (byte_s1 == hcbd_pkg::CH_LF) begin
					// Empty size line ends the body
					cnt_n = '0;
					ph_n  = hcbd_pkg::PH_DONE;
					dc_n  = 1'b0;
				end else if (hex.is_hex) begin
					cnt_n = {{(SIZE_BITS-4){1'b0}}, hex.value};
					ph_n  = hcbd_pkg::PH_SIZE;
				end else begin
					cnt_n = '0;
					dc_n  = 1'b1;
					ph_n  = hcbd_pkg::PH_SIZE;
				end
			end
			hcbd_pkg::PH_SIZE: begin
				if (byte_s1 == hcbd_pkg::CH_LF) begin
					ph_n = (cnt_b == '0) ? hcbd_pkg::PH_DONE : hcbd_pkg::PH_DATA;
					dc_n = 1'b0;
				end else if (!dc_b && hex.is_hex) begin
					// Saturate when the next digit would not fit
					if (cnt_b[SIZE_BITS-1 -: 4] != 4'd0) begin
						ov_n  = 1'b1;
						cnt_n = '1;
					end else begin
						cnt_n = cnt_shift;
					end
				end else begin
					dc_n = 1'b1;
				end
			end
			hcbd_pkg::PH_DATA: begin
				valid_n = 1'b1;
				cnt_n   = cnt_dec;
				if (cnt_dec == '0) begin
					last_n = 1'b1;
					ph_n   = hcbd_pkg::PH_TAIL;
				end
			end
			hcbd_pkg::PH_TAIL: begin
				if (byte_s1 == hcbd_pkg::CH_LF) begin
					ph_n = hcbd_pkg::PH_LEAD;
					dc_n = 1'b0;
				end
			end
			default: begin
				ph_n = ph_b;
			end
		endcase
	end

	// Stage valid bits and decoder state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1        <= 1'b0;
			valid_s2        <= 1'b0;
			phase_q         <= hcbd_pkg::PH_LEAD;
			count_q         <= '0;
			digits_closed_q <= 1'b0;
			overflow_q      <= 1'b0;
		end else begin
			if (in_ready) begin
				valid_s1 <= in_valid;
			end
			if (adv_s1) begin
				valid_s2 <= 1'b1;
			end else if (adv_s2) begin
				valid_s2 <= 1'b0;
			end
			if (adv_s1) begin
				phase_q         <= ph_n;
				count_q         <= cnt_n;
				digits_closed_q <= dc_n;
				overflow_q      <= ov_n;
			end
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			byte_s1     <= byte_in;
			new_body_s1 <= new_body;
		end
		if (adv_s1) begin
			data_byte_s2  <= valid_n ? byte_s1 : 8'd0;
			data_valid_s2 <= valid_n;
			last_s2       <= last_n;
			done_s2       <= (ph_n == hcbd_pkg::PH_DONE);
			ovf_s2        <= ov_n;
		end
	end

	assign out_valid       = valid_s2;
	assign data_byte       = data_byte_s2;
	assign data_valid      = data_valid_s2;
	assign chunk_last_byte = last_s2;
	assign body_done       = done_s2;
	assign size_overflow   = ovf_s2;

`include "http_chunked_body_decoder_assert.svh"

	`HCBD_ASSERT_NOW(a_last_is_data, clk, arst_n, out_valid && chunk_last_byte, data_valid)
	`HCBD_ASSERT_NOW(a_nondata_zero, clk, arst_n, out_valid && !data_valid, data_byte == 8'd0)
	`HCBD_ASSERT_NOW(a_no_bubble, clk, arst_n, out_ready, in_ready)
	`HCBD_ASSERT_NEXT(a_done_holds, clk, arst_n,
		adv_s1 && !new_body_s1 && phase_q == hcbd_pkg::PH_DONE, phase_q == hcbd_pkg::PH_DONE)

endmodule
`default_nettype wire

// File: tb/sv/testbench.sv
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned SIZE_BITS = hcbd_pkg::SIZE_BITS_DEF;
	localparam int unsigned STALL_LIMIT = 2000;
	localparam int unsigned RANDOM_ITEMS = 240;

	typedef struct packed {
		logic [7:0] data;
		logic       valid;
		logic       last;
		logic       done;
		logic       ovf;
	} chunk_result_t;

	logic       clk;
	logic       arst_n;
	logic       in_valid;
	logic       in_ready;
	logic [7:0] byte_in;
	logic       new_body;
	logic       out_valid;
	logic       out_ready;
	logic [7:0] data_byte;
	logic       data_valid;
	logic       chunk_last_byte;
	logic       body_done;
	logic       size_overflow;

	// decoder state as predicted from the accepted items
	hcbd_pkg::phase_t     dec_phase;
	logic [SIZE_BITS-1:0] dec_count;
	logic                 dec_closed;
	logic                 dec_ovf;

	chunk_result_t decoded_q[$];
	int unsigned   error_count;
	int unsigned   sent_count;
	int unsigned   stall_cycles;
	bit            idle_on;

	http_chunked_body_decoder #(
		.SIZE_BITS(SIZE_BITS)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.byte_in(byte_in),
		.new_body(new_body),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.data_byte(data_byte),
		.data_valid(data_valid),
		.chunk_last_byte(chunk_last_byte),
		.body_done(body_done),
		.size_overflow(size_overflow)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// shift one hex digit into the size, saturating once it no longer fits
	function automatic void push_digit(input logic [3:0] nib);
		if (dec_count[SIZE_BITS-1 -: 4] != '0) begin
			dec_ovf = 1'b1;
			dec_count = '1;
		end else begin
			dec_count = {dec_count[SIZE_BITS-5:0], nib};
		end
	endfunction

	function automatic void close_size_line();
		dec_phase = (dec_count == '0) ? hcbd_pkg::PH_DONE : hcbd_pkg::PH_DATA;
		dec_closed = 1'b0;
	endfunction

	// advance the predicted decoder by one byte and queue the expected result
	function automatic void decode_byte(input logic [7:0] c, input logic nb);
		chunk_result_t r;
		logic          is_hex;
		logic [3:0]    nib;
		logic          is_space;
		r = '0;
		if (nb) begin
			dec_phase = hcbd_pkg::PH_LEAD;
			dec_count = '0;
			dec_closed = 1'b0;
			dec_ovf = 1'b0;
		end
		is_hex = 1'b1;
		nib = 4'd0;
		if (c >= 8'h30 && c <= 8'h39)
			nib = c[3:0];
		else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46))
			nib = c[3:0] + 4'd9;
		else
			is_hex = 1'b0;
		is_space = (c == hcbd_pkg::CH_SP) || (c == hcbd_pkg::CH_TAB) ||
			(c == hcbd_pkg::CH_VT) || (c == hcbd_pkg::CH_FF) ||
			(c == hcbd_pkg::CH_CR);
		case (dec_phase)
			hcbd_pkg::PH_LEAD: begin
				if (is_space) begin
				end else if (c == hcbd_pkg::CH_LF) begin
					dec_count = '0;
					close_size_line();
				end else if (is_hex) begin
					dec_count = '0;
					push_digit(nib);
					dec_phase = hcbd_pkg::PH_SIZE;
				end else begin
					dec_count = '0;
					dec_closed = 1'b1;
					dec_phase = hcbd_pkg::PH_SIZE;
				end
			end
			hcbd_pkg::PH_SIZE: begin
				if (c == hcbd_pkg::CH_LF)
					close_size_line();
				else if (!dec_closed && is_hex)
					push_digit(nib);
				else
					dec_closed = 1'b1;
			end
			hcbd_pkg::PH_DATA: begin
				r.valid = 1'b1;
				r.data = c;
				dec_count = dec_count - SIZE_BITS'(1);
				if (dec_count == '0) begin
					r.last = 1'b1;
					dec_phase = hcbd_pkg::PH_TAIL;
				end
			end
			hcbd_pkg::PH_TAIL: begin
				if (c == hcbd_pkg::CH_LF) begin
					dec_phase = hcbd_pkg::PH_LEAD;
					dec_closed = 1'b0;
				end
			end
			default: begin
			end
		endcase
		r.done = (dec_phase == hcbd_pkg::PH_DONE);
		r.ovf = dec_ovf;
		decoded_q.push_back(r);
	endfunction

	task automatic report_mismatch(input string what, input logic [7:0] got,
		input logic [7:0] want);
		error_count++;
		if (error_count <= 50)
			$display("ERROR at %0t: %s got %0h want %0h", $realtime, what, got, want);
	endtask

	// check each accepted result against the oldest prediction
	always @(posedge clk) begin
		chunk_result_t want;
		if (arst_n && out_valid && out_ready) begin
			if (decoded_q.size() == 0) begin
				report_mismatch("result with nothing pending", data_byte, 8'h00);
			end else begin
				want = decoded_q.pop_front();
				if (data_byte !== want.data)
					report_mismatch("data_byte", data_byte, want.data);
				if (data_valid !== want.valid)
					report_mismatch("data_valid", 8'(data_valid), 8'(want.valid));
				if (chunk_last_byte !== want.last)
					report_mismatch("chunk_last_byte", 8'(chunk_last_byte), 8'(want.last));
				if (body_done !== want.done)
					report_mismatch("body_done", 8'(body_done), 8'(want.done));
				if (size_overflow !== want.ovf)
					report_mismatch("size_overflow", 8'(size_overflow), 8'(want.ovf));
			end
		end
	end

	// end the run when nothing moves on either side for too long
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready)) begin
			stall_cycles <= 0;
		end else begin
			stall_cycles <= stall_cycles + 1;
			if (stall_cycles >= STALL_LIMIT) begin
				$display("Simulation FAILED");
				$finish;
			end
		end
	end

	// stall the result side in random bursts
	initial begin
		out_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (idle_on && $urandom_range(0, 7) == 0) begin
				out_ready = 1'b0;
				repeat ($urandom_range(1, 9)) @(negedge clk);
			end
			out_ready = 1'b1;
		end
	end

	// send one item; entered and left just after a falling edge
	task automatic send_item(input logic [7:0] b, input logic nb);
		if (idle_on && $urandom_range(0, 3) == 0) begin
			in_valid = 1'b0;
			repeat ($urandom_range(1, 9)) @(negedge clk);
		end
		in_valid = 1'b1;
		byte_in = b;
		new_body = nb;
		do
			@(posedge clk);
		while (!in_ready);
		decode_byte(b, nb);
		sent_count++;
		@(negedge clk);
	endtask

	task automatic send_text(input string s, input logic nb);
		for (int i = 0; i < s.len(); i++)
			send_item(s[i], (i == 0) ? nb : 1'b0);
	endtask

	task automatic send_crlf();
		send_item(hcbd_pkg::CH_CR, 1'b0);
		send_item(hcbd_pkg::CH_LF, 1'b0);
	endtask

	function automatic logic [7:0] pick_space();
		case ($urandom_range(0, 4))
			0: return hcbd_pkg::CH_SP;
			1: return hcbd_pkg::CH_TAB;
			2: return hcbd_pkg::CH_VT;
			3: return hcbd_pkg::CH_FF;
			default: return hcbd_pkg::CH_CR;
		endcase
	endfunction

	function automatic logic [7:0] pick_hex_char();
		string digits;
		digits = "0123456789abcdefABCDEF";
		return digits[$urandom_range(0, 21)];
	endfunction

	// all skipped white space, an extension, and payload at both byte extremes
	task automatic test_lead_space_and_extension();
		send_item(hcbd_pkg::CH_SP, 1'b1);
		send_item(hcbd_pkg::CH_TAB, 1'b0);
		send_item(hcbd_pkg::CH_VT, 1'b0);
		send_item(hcbd_pkg::CH_FF, 1'b0);
		send_item(hcbd_pkg::CH_CR, 1'b0);
		send_text("2;x", 1'b0);
		send_crlf();
		send_item(8'h00, 1'b0);
		send_item(8'hFF, 1'b0);
		send_item(hcbd_pkg::CH_LF, 1'b0);
	endtask

	// a sign reads as no digits, a 0x prefix reads as zero; bytes after the end are ignored
	task automatic test_no_digits_and_prefix();
		send_text("-1", 1'b1);
		send_item(hcbd_pkg::CH_LF, 1'b0);
		send_text("7", 1'b0);
		send_text("0x5", 1'b1);
		send_item(hcbd_pkg::CH_LF, 1'b0);
	endtask

	// one digit too many saturates the size and sets the sticky flag
	task automatic test_size_overflow();
		send_text("FFFFFFFFa", 1'b1);
		send_item(hcbd_pkg::CH_LF, 1'b0);
	endtask

	// one chunked body, mostly well formed, sometimes cut short
	task automatic send_random_body();
		int    nchunks;
		int    size;
		int    cut;
		bit    broken;
		string hex;
		nchunks = $urandom_range(1, 4);
		broken = ($urandom_range(0, 7) == 0);
		cut = $urandom_range(0, nchunks - 1);
		for (int n = 0; n < nchunks; n++) begin
			// size line: spaces, hex size, extension, line end
			repeat ($urandom_range(0, 2))
				send_item(pick_space(), n == 0);
			size = ($urandom_range(0, 15) == 0) ? $urandom_range(25, 60) :
				$urandom_range(1, 12);
			hex = $sformatf("%0h", size);
			if ($urandom_range(0, 1))
				hex = hex.toupper();
			repeat ($urandom_range(0, 3) == 0 ? $urandom_range(1, 2) : 0)
				hex = {"0", hex};
			send_text(hex, (n == 0) && ($urandom_range(0, 7) != 0));
			if ($urandom_range(0, 3) == 0)
				send_text(";ext=v", 1'b0);
			if ($urandom_range(0, 5) == 0)
				send_item(hcbd_pkg::CH_LF, 1'b0);
			else
				send_crlf();
			// payload with random content
			for (int k = 0; k < size; k++) begin
				if (broken && n == cut && k == size / 2)
					return;
				send_item(8'($urandom_range(0, 255)), 1'b0);
			end
			// line after the payload, sometimes with junk
			if ($urandom_range(0, 7) == 0)
				send_item(8'($urandom_range(0, 9)), 1'b0);
			send_crlf();
		end
		// terminating line: zero size or an empty line
		if ($urandom_range(0, 3) != 0)
			send_text("0", 1'b0);
		send_crlf();
		repeat ($urandom_range(0, 4) == 0 ? $urandom_range(1, 3) : 0)
			send_item(8'($urandom_range(0, 255)), 1'b0);
	endtask

	// a long size line, with or without overflow, then a few bytes before the next body
	task automatic send_long_size();
		send_item(pick_hex_char(), 1'b1);
		repeat ($urandom_range(7, 11))
			send_item(pick_hex_char(), 1'b0);
		send_crlf();
		repeat ($urandom_range(1, 6))
			send_item(8'($urandom_range(0, 255)), 1'b0);
	endtask

	task automatic send_noise();
		repeat ($urandom_range(1, 8))
			send_item(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0);
	endtask

	task automatic test_random_bodies();
		int unsigned goal;
		goal = sent_count + RANDOM_ITEMS;
		while (sent_count < goal) begin
			idle_on = ($urandom_range(0, 3) != 0);
			case ($urandom_range(0, 19))
				0: send_long_size();
				1, 2: send_noise();
				default: send_random_body();
			endcase
		end
	endtask

	// back-to-back traffic with no idling on either side
	task automatic test_back_to_back();
		idle_on = 1'b0;
		repeat (3)
			send_random_body();
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		byte_in = 8'h00;
		new_body = 1'b0;
		error_count = 0;
		sent_count = 0;
		stall_cycles = 0;
		idle_on = 1'b1;
		dec_phase = hcbd_pkg::PH_LEAD;
		dec_count = '0;
		dec_closed = 1'b0;
		dec_ovf = 1'b0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_lead_space_and_extension();
		test_no_digits_and_prefix();
		test_size_overflow();
		test_random_bodies();
		test_back_to_back();

		// drain the pipeline, then allow a few extra cycles
		in_valid = 1'b0;
		while (decoded_q.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		if (error_count == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

// File: filelist.f
+incdir+hw/rtl
hw/rtl/hcbd_pkg.sv
hw/rtl/http_chunked_body_decoder.sv
tb/sv/testbench.sv
